// ===== design/tstf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstf_pkg: shared definitions for the three-sum triplet finder
// Sizes, operation and status codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tstf_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;
   localparam int SUM_W        = DATA_W + 2;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   // pointers reach count + 1 during the outer skip
   localparam int PTR_W        = $clog2(MAX_ELEMENTS + 2);
   localparam logic [PTR_W-1:0] MAX_CNT = PTR_W'(MAX_ELEMENTS);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_FOUND  = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef enum logic [1:0] {
      RD_POS_M1 = 2'd0,
      RD_OUTER  = 2'd1,
      RD_LOW    = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       cfg_wr;
      logic       restart;
      logic       clear_count;
      logic       ins_start;
      logic       ins_shift;
      logic       ins_final;
      logic       fetch_init;
      rd_sel_type rd_sel;
      logic       load_first;
      logic       take_triplet;
      logic       low_inc;
      logic       high_dec;
      logic       outer_inc;
      logic       reset_pair;
      logic       status_wr;
      logic [1:0] status_code;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic ins_gt;
      logic outer_ok;
      logic pair_ok;
      logic sum_eq;
      logic sum_lt;
      logic low_ok;
      logic dup_eq;
      logic outer_lt_n;
      logic first_eq;
   } sts_type;

endpackage

// ===== design/three_sum_triplet_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_sum_triplet_finder: sorted store with two-pointer 3-sum search
// Loads signed elements into a store kept in ascending order; each fetch
// request resumes the search and returns the next distinct triplet that
// adds up to the programmed target, or a done status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | operation, element_value
//  rsp_    | out       | rsp_valid/rsp_stall | status, first/second/third
//  csr_    | in        | csr_valid/csr_ready | target_sum
//
//  Clear, unused op and store-full requests go straight to the response stage.
//  Load: each element shifted right costs a read state and a compare state;
//  the store has one write and two registered read ports, one shift per read.
//  Fetch: each pointer step is a read state then a compare state, plus the
//  per-outer-value setup and skip states; the pace is set by the read-then-compare
//  loop.
//  Reset is synchronous: empty store, target zero, search restarted.
//  A finished response sits in an output register; the next request is taken
//  while it waits, and the machine stalls only when a second response is due.
// ----------------------------------------------------------------------------
module three_sum_triplet_finder import tstf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic        [1:0]        req_operation,
   input  logic signed [DATA_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic        [1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_first_value,
   output logic signed [DATA_W-1:0] rsp_second_value,
   output logic signed [DATA_W-1:0] rsp_third_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic signed [DATA_W-1:0] csr_target_sum
);

   cmd_type cmd;
   sts_type sts;
   logic    idle;

   // sequencer: one state per read, compare or write step
   tstf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .sts           (sts),
      .cmd           (cmd),
      .idle          (idle)
   );

   // store, pointers and sum compare
   tstf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_element_value (req_element_value),
      .csr_target_sum    (csr_target_sum),
      .rsp_status        (rsp_status),
      .rsp_first_value   (rsp_first_value),
      .rsp_second_value  (rsp_second_value),
      .rsp_third_value   (rsp_third_value)
   );

`ifndef ASSERT_OFF
   // every accepted request takes the sequencer out of idle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !idle)
      else $error("sequencer idle right after a request");

   // a found triplet is always in ascending order
   a_triplet_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FOUND) |->
         (rsp_first_value <= rsp_second_value &&
          rsp_second_value <= rsp_third_value))
      else $error("triplet out of order");

   // only a found triplet carries values
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FOUND) |->
         (rsp_first_value == '0 && rsp_second_value == '0 &&
          rsp_third_value == '0))
      else $error("values on a response without a triplet");
`endif

endmodule

// ===== design/tstf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstf_ctrl: sequencer for the triplet finder
// One-hot state machine that runs insertion and the two-pointer search by
// issuing commands to the datapath, and owns the handshakes.
// ----------------------------------------------------------------------------
module tstf_ctrl import tstf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       idle
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_INS_RD   = 12'b0000_0000_0010,
      S_INS_CMP  = 12'b0000_0000_0100,
      S_OUTER    = 12'b0000_0000_1000,
      S_FIRST    = 12'b0000_0001_0000,
      S_PAIR_RD  = 12'b0000_0010_0000,
      S_PAIR_CMP = 12'b0000_0100_0000,
      S_DUP_RD   = 12'b0000_1000_0000,
      S_DUP_CMP  = 12'b0001_0000_0000,
      S_SKIP_RD  = 12'b0010_0000_0000,
      S_SKIP_CMP = 12'b0100_0000_0000,
      S_RESP     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   assign idle       = (state_ff == S_IDLE);
   assign csr_ready  = idle;
   assign req_stall  = !idle || csr_valid;   // config write wins
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_POS_M1;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cmd.cfg_wr  = 1'b1;
               cmd.restart = 1'b1;
            end else if (req_accept) begin
               case (req_operation)
                  OP_CLEAR: begin
                     cmd.clear_count = 1'b1;
                     cmd.restart     = 1'b1;
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = ST_ACCEPT;
                     state_in        = S_RESP;
                  end
                  OP_LOAD: begin
                     if (sts.full) begin
                        cmd.status_wr   = 1'b1;
                        cmd.status_code = ST_FULL;
                        state_in        = S_RESP;
                     end else begin
                        cmd.ins_start = 1'b1;
                        cmd.restart   = 1'b1;
                        state_in      = S_INS_RD;
                     end
                  end
                  OP_FETCH: begin
                     cmd.fetch_init = 1'b1;
                     state_in       = S_OUTER;
                  end
                  default: begin
                     cmd.status_wr   = 1'b1;
                     cmd.status_code = ST_ACCEPT;
                     state_in        = S_RESP;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (sts.pos_zero) begin
               cmd.ins_final   = 1'b1;
               cmd.status_wr   = 1'b1;
               cmd.status_code = ST_ACCEPT;
               state_in        = S_RESP;
            end else begin
               cmd.rd_sel = RD_POS_M1;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.ins_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               cmd.ins_final   = 1'b1;
               cmd.status_wr   = 1'b1;
               cmd.status_code = ST_ACCEPT;
               state_in        = S_RESP;
            end
         end
         S_OUTER: begin
            if (sts.outer_ok) begin
               cmd.rd_sel = RD_OUTER;
               state_in   = S_FIRST;
            end else begin
               cmd.status_wr   = 1'b1;
               cmd.status_code = ST_DONE;
               state_in        = S_RESP;
            end
         end
         S_FIRST: begin
            cmd.load_first = 1'b1;
            state_in       = S_PAIR_RD;
         end
         S_PAIR_RD: begin
            if (sts.pair_ok) begin
               cmd.rd_sel = RD_LOW;
               state_in   = S_PAIR_CMP;
            end else begin
               cmd.outer_inc = 1'b1;
               state_in      = S_SKIP_RD;
            end
         end
         S_PAIR_CMP: begin
            if (sts.sum_eq) begin
               cmd.take_triplet = 1'b1;
               cmd.low_inc      = 1'b1;
               cmd.status_wr    = 1'b1;
               cmd.status_code  = ST_FOUND;
               state_in         = S_DUP_RD;
            end else if (sts.sum_lt) begin
               cmd.low_inc = 1'b1;
               state_in    = S_PAIR_RD;
            end else begin
               cmd.high_dec = 1'b1;
               state_in     = S_PAIR_RD;
            end
         end
         S_DUP_RD: begin
            if (sts.low_ok) begin
               cmd.rd_sel = RD_LOW;
               state_in   = S_DUP_CMP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DUP_CMP: begin
            if (sts.dup_eq) begin
               cmd.low_inc = 1'b1;
               state_in    = S_DUP_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SKIP_RD: begin
            if (sts.outer_lt_n) begin
               cmd.rd_sel = RD_OUTER;
               state_in   = S_SKIP_CMP;
            end else begin
               cmd.reset_pair = 1'b1;
               state_in       = S_OUTER;
            end
         end
         S_SKIP_CMP: begin
            if (sts.first_eq) begin
               cmd.outer_inc = 1'b1;
               state_in      = S_SKIP_RD;
            end else begin
               cmd.reset_pair = 1'b1;
               state_in       = S_OUTER;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/tstf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstf_dp: datapath of the triplet finder
// Sorted element store, search pointers, 34-bit sum compare and the
// result and response registers.
// ----------------------------------------------------------------------------
module tstf_dp import tstf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic signed [DATA_W-1:0] csr_target_sum,
   output logic        [1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_first_value,
   output logic signed [DATA_W-1:0] rsp_second_value,
   output logic signed [DATA_W-1:0] rsp_third_value
);

   logic signed [DATA_W-1:0] store_mem [MAX_ELEMENTS];

   logic [PTR_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] outer_ff, outer_in;
   logic [PTR_W-1:0] low_ff, low_in;
   logic [PTR_W-1:0] high_ff, high_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic             started_ff, started_in;
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic signed [DATA_W-1:0] elem_ff, elem_in;
   logic signed [DATA_W-1:0] first_ff, first_in;
   logic signed [SUM_W-1:0]  need_ff, need_in;
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [1:0]               res_status_ff, res_status_in;
   logic signed [DATA_W-1:0] res_a_ff, res_a_in;
   logic signed [DATA_W-1:0] res_b_ff, res_b_in;
   logic signed [DATA_W-1:0] res_c_ff, res_c_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_a_ff, rsp_a_in;
   logic signed [DATA_W-1:0] rsp_b_ff, rsp_b_in;
   logic signed [DATA_W-1:0] rsp_c_ff, rsp_c_in;

   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic                     mem_wr;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [SUM_W-1:0]  pair_sum;
   logic [PTR_W-1:0]         count_m1;
   logic [PTR_W:0]           outer_p2;

   assign count_m1 = (count_ff != '0) ? count_ff - PTR_W'(1) : '0;
   assign outer_p2 = {1'b0, outer_ff} + (PTR_W+1)'(2);
   assign pair_sum = SUM_W'(rd_a_ff) + SUM_W'(rd_b_ff);

   always_comb begin
      sts.full       = (count_ff >= MAX_CNT);
      sts.pos_zero   = (pos_ff == '0);
      sts.ins_gt     = (rd_a_ff > elem_ff);
      sts.outer_ok   = (outer_p2 < {1'b0, count_ff});
      sts.pair_ok    = (low_ff < high_ff) && (high_ff < count_ff);
      sts.sum_eq     = (pair_sum == need_ff);
      sts.sum_lt     = (pair_sum < need_ff);
      sts.low_ok     = (low_ff < high_ff);
      sts.dup_eq     = (rd_a_ff == res_b_ff);
      sts.outer_lt_n = (outer_ff < count_ff);
      sts.first_eq   = (rd_a_ff == first_ff);
   end

   // read port A address; port B always follows the high pointer
   always_comb begin
      case (cmd.rd_sel)
         RD_POS_M1: rd_addr = ADDR_W'(pos_ff - PTR_W'(1));
         RD_OUTER:  rd_addr = outer_ff[ADDR_W-1:0];
         RD_LOW:    rd_addr = low_ff[ADDR_W-1:0];
         default:   rd_addr = outer_ff[ADDR_W-1:0];
      endcase
   end

   assign mem_wr  = cmd.ins_shift || cmd.ins_final;
   assign wr_addr = pos_ff[ADDR_W-1:0];
   assign wr_data = cmd.ins_shift ? rd_a_ff : elem_ff;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_mem[rd_addr];
      rd_b_ff <= store_mem[high_ff[ADDR_W-1:0]];
   end

   always_comb begin
      count_in      = count_ff;
      outer_in      = outer_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      pos_in        = pos_ff;
      started_in    = started_ff;
      target_in     = target_ff;
      elem_in       = elem_ff;
      first_in      = first_ff;
      need_in       = need_ff;
      res_status_in = res_status_ff;
      res_a_in      = res_a_ff;
      res_b_in      = res_b_ff;
      res_c_in      = res_c_ff;
      rsp_status_in = rsp_status_ff;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_c_in      = rsp_c_ff;

      if (cmd.cfg_wr) begin
         target_in = csr_target_sum;
      end
      if (cmd.restart) begin
         started_in = 1'b0;
         outer_in   = '0;
         low_in     = PTR_W'(1);
         high_in    = cmd.clear_count ? '0 : count_m1;
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.ins_start) begin
         pos_in  = count_ff;
         elem_in = req_element_value;
      end
      if (cmd.ins_shift) begin
         pos_in = pos_ff - PTR_W'(1);
      end
      if (cmd.ins_final) begin
         count_in = count_ff + PTR_W'(1);
      end
      if (cmd.fetch_init && !started_ff) begin
         started_in = 1'b1;
         outer_in   = '0;
         low_in     = PTR_W'(1);
         high_in    = count_m1;
      end
      if (cmd.load_first) begin
         first_in = rd_a_ff;
         need_in  = SUM_W'(target_ff) - SUM_W'(rd_a_ff);
      end
      if (cmd.take_triplet) begin
         res_a_in = first_ff;
         res_b_in = rd_a_ff;
         res_c_in = rd_b_ff;
      end
      if (cmd.low_inc) begin
         low_in = low_ff + PTR_W'(1);
      end
      if (cmd.high_dec) begin
         high_in = high_ff - PTR_W'(1);
      end
      if (cmd.outer_inc) begin
         outer_in = outer_ff + PTR_W'(1);
      end
      if (cmd.reset_pair) begin
         low_in  = outer_ff + PTR_W'(1);
         high_in = count_m1;
      end
      if (cmd.status_wr) begin
         res_status_in = cmd.status_code;
      end
      if (cmd.load_rsp) begin
         rsp_status_in = res_status_ff;
         if (res_status_ff == ST_FOUND) begin
            rsp_a_in = res_a_ff;
            rsp_b_in = res_b_ff;
            rsp_c_in = res_c_ff;
         end else begin
            rsp_a_in = '0;
            rsp_b_in = '0;
            rsp_c_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         outer_ff   <= '0;
         low_ff     <= PTR_W'(1);
         high_ff    <= '0;
         started_ff <= 1'b0;
         target_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         outer_ff   <= outer_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         started_ff <= started_in;
         target_ff  <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      elem_ff       <= elem_in;
      first_ff      <= first_in;
      need_ff       <= need_in;
      res_status_ff <= res_status_in;
      res_a_ff      <= res_a_in;
      res_b_ff      <= res_b_in;
      res_c_ff      <= res_c_in;
      rsp_status_ff <= rsp_status_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_c_ff      <= rsp_c_in;
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_first_value  = rsp_a_ff;
   assign rsp_second_value = rsp_b_ff;
   assign rsp_third_value  = rsp_c_ff;

endmodule
